// ===== rtl/tcq_pkg.sv =====
`default_nettype none

package tcq_pkg;

   // Queue geometry.
   localparam int QUEUE_DEPTH = 16;
   localparam int ID_WIDTH    = 16;
   localparam int NUM_CLASSES = 3;

   localparam int PTR_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
   localparam int TASK_W = 16;
   localparam int RUN_W  = 4;
   localparam int HPN_W  = 4;

   localparam logic [TASK_W-1:0] ID_MASK =
      (ID_WIDTH >= TASK_W) ? {TASK_W{1'b1}} : TASK_W'((64'd1 << ID_WIDTH) - 64'd1);

   localparam logic [RUN_W-1:0] RUN_MAX   = {RUN_W{1'b1}};
   localparam logic [HPN_W-1:0] HPN_RESET = HPN_W'(3);

   // The result buffer has three entries; this is the index of the last one.
   localparam logic [1:0] RSP_BUF_LAST = 2'd2;

   // Command codes.
   localparam logic [1:0] CMD_ENQ   = 2'd0;
   localparam logic [1:0] CMD_FETCH = 2'd1;
   localparam logic [1:0] CMD_STOP  = 2'd2;

   // Class codes.
   localparam logic [1:0] CLS_LOW    = 2'd0;
   localparam logic [1:0] CLS_NORMAL = 2'd1;
   localparam logic [1:0] CLS_HIGH   = 2'd2;
   localparam logic [1:0] CLS_NONE   = 2'd3;

   // One result item, ok in the lowest bit once packed.
   typedef struct packed {
      logic [1:0]        served_class;
      logic [TASK_W-1:0] task_out;
      logic              task_valid;
      logic              ok;
   } tcq_rsp_type;

   // Decision of the scheduler for the item being accepted.
   typedef struct packed {
      logic ok;
      logic task_valid;
      logic [1:0] served_class;
   } tcq_res_type;

   // Store accesses issued by the scheduler.
   typedef struct packed {
      logic              wr_en;
      logic [1:0]        wr_cls;
      logic [PTR_W-1:0]  wr_ptr;
      logic [TASK_W-1:0] wr_data;
      logic [1:0]        rd_cls;
      logic [PTR_W-1:0]  rd_ptr;
   } tcq_mem_op_type;

   function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
      logic [PTR_W-1:0] r;
      if (p == PTR_W'(QUEUE_DEPTH - 1)) begin
         r = '0;
      end else begin
         r = p + 1'b1;
      end
      return r;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/tcq_store.sv =====
`default_nettype none

module tcq_store (
   input  wire logic                           clock,
   input  wire tcq_pkg::tcq_mem_op_type        mem_op,
   output      logic [tcq_pkg::TASK_W-1:0]     rd_data_ff
);

   logic [tcq_pkg::TASK_W-1:0] store_ff [tcq_pkg::NUM_CLASSES][tcq_pkg::QUEUE_DEPTH];

   always_ff @(posedge clock) begin
      if (mem_op.wr_en) begin
         store_ff[mem_op.wr_cls][mem_op.wr_ptr] <= mem_op.wr_data;
      end
   end

   // The scheduler only points the read port at a real class.
   always_ff @(posedge clock) begin
      rd_data_ff <= store_ff[mem_op.rd_cls][mem_op.rd_ptr];
   end

endmodule

`default_nettype wire

// ===== rtl/tcq_sched.sv =====
`default_nettype none

module tcq_sched (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          accept,
   input  wire logic [1:0]                    cmd,
   input  wire logic [tcq_pkg::TASK_W-1:0]    task_id,
   input  wire logic [1:0]                    task_class,
   input  wire logic [tcq_pkg::HPN_W-1:0]     highs_per_normal,
   output      tcq_pkg::tcq_res_type          res,
   output      tcq_pkg::tcq_mem_op_type       mem_op
);

   logic [tcq_pkg::CNT_W-1:0] fill_ff [tcq_pkg::NUM_CLASSES];
   logic [tcq_pkg::CNT_W-1:0] fill_in [tcq_pkg::NUM_CLASSES];
   logic [tcq_pkg::PTR_W-1:0] head_ff [tcq_pkg::NUM_CLASSES];
   logic [tcq_pkg::PTR_W-1:0] head_in [tcq_pkg::NUM_CLASSES];
   logic [tcq_pkg::PTR_W-1:0] tail_ff [tcq_pkg::NUM_CLASSES];
   logic [tcq_pkg::PTR_W-1:0] tail_in [tcq_pkg::NUM_CLASSES];
   logic [tcq_pkg::RUN_W-1:0] run_ff;
   logic [tcq_pkg::RUN_W-1:0] run_in;
   logic                      stopped_ff;
   logic                      stopped_in;

   logic       cls_ok;
   logic [1:0] cls_idx;
   logic       enq_ok;
   logic       have;
   logic [1:0] pick;

   assign cls_ok  = (task_class != tcq_pkg::CLS_NONE);
   assign cls_idx = cls_ok ? task_class : tcq_pkg::CLS_LOW;
   assign enq_ok  = !stopped_ff && cls_ok &&
                    (fill_ff[cls_idx] != tcq_pkg::CNT_W'(tcq_pkg::QUEUE_DEPTH));

   // High runs until the run count reaches the weight and a normal task waits.
   always_comb begin
      have = 1'b1;
      pick = tcq_pkg::CLS_LOW;
      priority if (fill_ff[tcq_pkg::CLS_HIGH] != '0) begin
         if ((run_ff >= highs_per_normal) && (fill_ff[tcq_pkg::CLS_NORMAL] != '0)) begin
            pick = tcq_pkg::CLS_NORMAL;
         end else begin
            pick = tcq_pkg::CLS_HIGH;
         end
      end else if (fill_ff[tcq_pkg::CLS_NORMAL] != '0) begin
         pick = tcq_pkg::CLS_NORMAL;
      end else if (fill_ff[tcq_pkg::CLS_LOW] != '0) begin
         pick = tcq_pkg::CLS_LOW;
      end else begin
         have = 1'b0;
      end
   end

   always_comb begin
      fill_in    = fill_ff;
      head_in    = head_ff;
      tail_in    = tail_ff;
      run_in     = run_ff;
      stopped_in = stopped_ff;
      res        = '0;

      mem_op         = '0;
      mem_op.wr_cls  = cls_idx;
      mem_op.wr_ptr  = tail_ff[cls_idx];
      mem_op.wr_data = task_id & tcq_pkg::ID_MASK;
      mem_op.rd_cls  = pick;
      mem_op.rd_ptr  = head_ff[pick];

      if (accept) begin
         unique case (cmd)
            tcq_pkg::CMD_ENQ: begin
               if (enq_ok) begin
                  tail_in[cls_idx] = tcq_pkg::next_ptr(tail_ff[cls_idx]);
                  fill_in[cls_idx] = fill_ff[cls_idx] + 1'b1;
                  mem_op.wr_en     = 1'b1;
                  res.ok           = 1'b1;
               end
            end
            tcq_pkg::CMD_FETCH: begin
               if (!stopped_ff && have) begin
                  head_in[pick]    = tcq_pkg::next_ptr(head_ff[pick]);
                  fill_in[pick]    = fill_ff[pick] - 1'b1;
                  res.ok           = 1'b1;
                  res.task_valid   = 1'b1;
                  res.served_class = pick;
                  if (pick == tcq_pkg::CLS_HIGH) begin
                     if (run_ff != tcq_pkg::RUN_MAX) begin
                        run_in = run_ff + 1'b1;
                     end
                  end else begin
                     run_in = '0;
                  end
               end
            end
            tcq_pkg::CMD_STOP: begin
               if (!stopped_ff) begin
                  stopped_in = 1'b1;
                  res.ok     = 1'b1;
                  for (int c = 0; c < tcq_pkg::NUM_CLASSES; c++) begin
                     fill_in[c] = '0;
                     head_in[c] = '0;
                     tail_in[c] = '0;
                  end
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int c = 0; c < tcq_pkg::NUM_CLASSES; c++) begin
            fill_ff[c] <= '0;
            head_ff[c] <= '0;
            tail_ff[c] <= '0;
         end
         run_ff     <= '0;
         stopped_ff <= 1'b0;
      end else begin
         fill_ff    <= fill_in;
         head_ff    <= head_in;
         tail_ff    <= tail_in;
         run_ff     <= run_in;
         stopped_ff <= stopped_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/tcq_rsp_fifo.sv =====
`default_nettype none

module tcq_rsp_fifo (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  push,
   input  wire tcq_pkg::tcq_rsp_type  push_data,
   input  wire logic                  pop,
   output      tcq_pkg::tcq_rsp_type  head_data,
   output      logic                  not_empty,
   output      logic [1:0]            count_ff
);

   tcq_pkg::tcq_rsp_type entry_ff [3];
   logic [1:0] wr_ptr_ff;
   logic [1:0] rd_ptr_ff;
   logic [1:0] count_in;
   logic       do_pop;

   assign not_empty = (count_ff != 2'd0);
   assign do_pop    = pop && not_empty;
   assign head_data = entry_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      if (push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!push && do_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == tcq_pkg::RSP_BUF_LAST) ? 2'd0 : wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= (rd_ptr_ff == tcq_pkg::RSP_BUF_LAST) ? 2'd0 : rd_ptr_ff + 1'b1;
         end
      end
   end

endmodule

`default_nettype wire

// ===== rtl/three_class_weighted_task_queue_core.sv =====
`default_nettype none

// Three-class weighted task queue. Each item on the req_ stream is one command
// (enqueue, fetch or stop, in req_tuser) and every item yields exactly one
// result item on the rsp_ stream, in the order the commands were taken.
// Enqueue places a task ID in the FIFO of its class (low, normal, high); fetch
// serves high until highs_per_normal highs have run back to back, then lets a
// waiting normal task through, and serves low only when the other two are empty.
// Stop flushes all queues and refuses every later enqueue and fetch.
// The csr_ port writes highs_per_normal; it is always ready and is meant to be
// written only while no command is in flight.
// Throughput is one item per cycle while req_tready is high: the scheduling decision
// is made in the cycle the item is taken and the task store answers from a registered
// read; an accepted item passes the read stage and then the result buffer to rsp_tvalid.
// A three-entry result buffer sits on the output, so req_tready depends only on
// registers; when the receiver stalls the buffer fills and req_tready drops
// once it and the read stage together hold three items.
// Reset empties all queues, clears the high run count and the stopped state,
// sets highs_per_normal to 3 and drops every pending result.

module three_class_weighted_task_queue_core (
   input  wire logic                              clock,
   input  wire logic                              reset,
   // Request stream.
   input  wire logic                              req_tvalid,
   output      logic                              req_tready,
   input  wire logic [23:0]                       req_tdata,   // task_id[15:0], task_class[17:16]
   input  wire logic [1:0]                        req_tuser,   // cmd[1:0]
   // Result stream.
   output      logic                              rsp_tvalid,
   input  wire logic                              rsp_tready,
   output      logic [23:0]                       rsp_tdata,   // ok[0], task_valid[1],
                                                               // task_out[17:2], served_class[19:18]
   // Register write.
   input  wire logic                              csr_valid,
   output      logic                              csr_ready,
   input  wire logic [tcq_pkg::HPN_W-1:0]         csr_wdata
);

   logic                          req_accept;
   logic [tcq_pkg::HPN_W-1:0]     hpn_ff;
   tcq_pkg::tcq_res_type          res;
   tcq_pkg::tcq_mem_op_type       mem_op;
   logic [tcq_pkg::TASK_W-1:0]    rd_data_ff;

   // Read stage: decision flags wait here for the store's read data.
   logic                          p_valid_ff;
   tcq_pkg::tcq_res_type          p_res_ff;
   tcq_pkg::tcq_rsp_type          p_rsp;

   tcq_pkg::tcq_rsp_type          buf_head;
   logic                          buf_not_empty;
   logic [1:0]                    buf_count;
   logic [2:0]                    occupancy;

   // An item is only taken when the buffer has room for it and for the item
   // already in the read stage, even if nothing is popped meanwhile.
   assign occupancy  = {1'b0, buf_count} + {2'b00, p_valid_ff};
   assign req_tready = (occupancy <= 3'd2);
   assign req_accept = req_tvalid && req_tready;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         hpn_ff <= tcq_pkg::HPN_RESET;
      end else if (csr_valid) begin
         hpn_ff <= csr_wdata;
      end
   end

   tcq_sched u_sched (
      .clock            (clock),
      .reset            (reset),
      .accept           (req_accept),
      .cmd              (req_tuser),
      .task_id          (req_tdata[15:0]),
      .task_class       (req_tdata[17:16]),
      .highs_per_normal (hpn_ff),
      .res              (res),
      .mem_op           (mem_op)
   );

   tcq_store u_store (
      .clock      (clock),
      .mem_op     (mem_op),
      .rd_data_ff (rd_data_ff)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         p_valid_ff <= 1'b0;
      end else begin
         p_valid_ff <= req_accept;
      end
   end

   always_ff @(posedge clock) begin
      p_res_ff <= res;
   end

   // The task ID reads as zero whenever no task is delivered.
   always_comb begin
      p_rsp.ok           = p_res_ff.ok;
      p_rsp.task_valid   = p_res_ff.task_valid;
      p_rsp.served_class = p_res_ff.served_class;
      p_rsp.task_out     = p_res_ff.task_valid ? rd_data_ff : '0;
   end

   tcq_rsp_fifo u_rsp_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (p_valid_ff),
      .push_data (p_rsp),
      .pop       (rsp_tready),
      .head_data (buf_head),
      .not_empty (buf_not_empty),
      .count_ff  (buf_count)
   );

   assign rsp_tvalid = buf_not_empty;
   assign rsp_tdata  = {4'b0000, buf_head};

   // The result buffer never receives an item it has no room for.
   assert property (@(posedge clock) disable iff (reset)
      !(p_valid_ff && (buf_count == 2'd3) && !(rsp_tvalid && rsp_tready)))
      else $error("result buffer overflow");

   // A delivered task always comes with ok set and a real class.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tdata[1]) |->
         (rsp_tdata[0] && (rsp_tdata[19:18] != tcq_pkg::CLS_NONE)))
      else $error("delivered task without ok or with a bad class");

   // Every accepted item reaches the read stage in the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      req_accept |=> p_valid_ff)
      else $error("accepted item lost before the read stage");

endmodule

`default_nettype wire
